FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/bdc_pkg.sv
// types and constants of the button debouncer
`timescale 1ns / 1ps

package bdc_pkg;

    localparam int TIME_BITS  = 32;
    localparam int MS_W       = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = CFG_W'(50);
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(1000);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_DEBOUNCE   = 1'b0;
    localparam t_cfg_idx CFG_LONG_PRESS = 1'b1;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
    } t_cfg;

    typedef struct packed {
        logic            pin_level;
        logic [MS_W-1:0] time_ms;
    } t_sample;

    typedef struct packed {
        logic    valid;
        t_sample sample;
    } t_stage;

endpackage

FILE: hw/rtl/bdc_if.sv
// valid/ready channel interfaces for sample and result beats
`timescale 1ns / 1ps

interface bdc_in_if
    import bdc_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            pin_level;
    logic [MS_W-1:0] time_ms;

    modport source (output valid, output pin_level, output time_ms, input ready);
    modport sink   (input valid, input pin_level, input time_ms, output ready);
endinterface

interface bdc_out_if;
    logic valid;
    logic ready;
    logic is_down;
    logic click;
    logic long_press;

    modport source (output valid, output is_down, output click, output long_press,
                    input ready);
    modport sink   (input valid, input is_down, input click, input long_press,
                    output ready);
endinterface

FILE: hw/rtl/bdc_cfg.sv
// configuration registers for debounce and long-press times
`timescale 1ns / 1ps

module bdc_cfg
    import bdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE:   n_cfg.debounce_time   = i_cfg_data;
                CFG_LONG_PRESS: n_cfg.long_press_time = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time   <= DEBOUNCE_RESET;
            r_cfg.long_press_time <= LONG_PRESS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/bdc_in_reg.sv
// input register for pin sample beats
`timescale 1ns / 1ps

module bdc_in_reg
    import bdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdc_in_if.sink      i_in,
    input  logic        i_ready,
    output t_stage      o_stage
);

    logic    r_valid;
    logic    n_valid;
    t_sample r_sample;
    logic    w_ready;

    assign w_ready    = !r_valid || i_ready;
    assign i_in.ready = w_ready;
    assign n_valid    = w_ready ? i_in.valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_ready) begin
            r_sample.pin_level <= i_in.pin_level;
            r_sample.time_ms   <= i_in.time_ms;
        end
    end

    assign o_stage.valid  = r_valid;
    assign o_stage.sample = r_sample;

endmodule

FILE: hw/rtl/bdc_core.sv
// debounce state update and result register
`timescale 1ns / 1ps

module bdc_core
    import bdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_stage      i_stage,
    output logic        o_ready,
    bdc_out_if.source   o_out
);

    logic  r_stable;
    logic  r_long_rep;
    t_time r_last_change;
    t_time r_press_start;

    logic  n_stable;
    logic  n_long_rep;
    t_time n_last_change;
    t_time n_press_start;

    logic  r_out_valid;
    logic  r_is_down;
    logic  r_click;
    logic  r_long_press;

    logic  n_click;
    logic  n_long_press;

    logic  w_fire;
    logic  w_pressed;
    logic  w_change;
    logic  w_press_acc;
    logic  w_long_mid;
    t_time w_now;
    t_time w_since_change;
    t_time w_since_press;

    assign o_ready = !r_out_valid || o_out.ready;
    assign w_fire  = i_stage.valid && o_ready;

    always_comb begin
        w_pressed      = !i_stage.sample.pin_level;
        w_now          = TIME_BITS'(i_stage.sample.time_ms);
        w_since_change = w_now - r_last_change;
        w_change       = (w_pressed != r_stable) &&
                         (w_since_change >= TIME_BITS'(i_cfg.debounce_time));
        w_press_acc    = w_change && w_pressed;

        n_stable      = w_change ? w_pressed : r_stable;
        n_last_change = w_change ? w_now : r_last_change;
        n_press_start = w_press_acc ? w_now : r_press_start;
        w_long_mid    = w_press_acc ? 1'b0 : r_long_rep;

        // a newly accepted press has zero elapsed time
        w_since_press = w_press_acc ? '0 : (w_now - r_press_start);

        n_click      = r_stable && !n_stable && !w_long_mid;
        n_long_press = n_stable && !w_long_mid &&
                       (w_since_press >= TIME_BITS'(i_cfg.long_press_time));
        n_long_rep   = w_long_mid || n_long_press;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= 1'b0;
            r_long_rep    <= 1'b0;
            r_last_change <= '0;
            r_press_start <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_fire) begin
                r_stable      <= n_stable;
                r_long_rep    <= n_long_rep;
                r_last_change <= n_last_change;
                r_press_start <= n_press_start;
            end
            if (o_ready) begin
                r_out_valid <= i_stage.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_is_down    <= n_stable;
            r_click      <= n_click;
            r_long_press <= n_long_press;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.is_down    = r_is_down;
    assign o_out.click      = r_click;
    assign o_out.long_press = r_long_press;

endmodule

FILE: hw/rtl/button_debounce_click_longpress.sv
// a sample beat passes the input register and then the result register before its result beat can be taken
// throughput: one sample beat per cycle while result beats are taken; a waiting result stalls the state update
// one sample can be taken while a finished result waits, held in the input register
// reset: synchronous, active low; clears the debounce state and both valids,
// and loads debounce_time with 50 and long_press_time with 1000
`timescale 1ns / 1ps

module button_debounce_click_longpress
    import bdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    bdc_in_if.sink           i_in,
    bdc_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg   w_cfg;
    t_stage w_stage;
    logic   w_core_ready;

    bdc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bdc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (w_core_ready),
        .o_stage (w_stage)
    );

    bdc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_stage (w_stage),
        .o_ready (w_core_ready),
        .o_out   (o_out)
    );

endmodule

FILE: hw/rtl/bdc_checker.sv
// port-level checks on result beats of the button debouncer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_is_down,
    input logic i_click,
    input logic i_long_press
);

    logic       w_stall;
    logic [2:0] w_beat;

    assign w_stall = i_out_valid && !i_out_ready;
    assign w_beat  = {i_is_down, i_click, i_long_press};

    // click and long press never share a beat
    `ASSERT_IMPL(a_excl, i_clk, i_rst_n, i_out_valid, !(i_click && i_long_press))
    // click only on a released level
    `ASSERT_IMPL(a_click_up, i_clk, i_rst_n, i_out_valid && i_click, !i_is_down)
    // long press only while held
    `ASSERT_IMPL(a_long_down, i_clk, i_rst_n, i_out_valid && i_long_press, i_is_down)
    // stalled beat holds
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_stall, i_out_valid && $stable(w_beat))

endmodule

bind button_debounce_click_longpress bdc_checker u_bdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_is_down    (o_out.is_down),
    .i_click      (o_out.click),
    .i_long_press (o_out.long_press)
);
